@@ rtl/core/bxsh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bxsh_pkg
// Shared types, constants and mixing functions of the xor/shift hash block.
// ----------------------------------------------------------------------------
package bxsh_pkg;

	localparam int HASH_W         = 32;
	localparam int COUNT_OUT_W    = 48;
	localparam int COUNT_BITS_DEF = 48;

	localparam logic [HASH_W-1:0] FINAL_MUL = 32'hA5A5A5A5;

	localparam logic [1:0] ACT_ADD     = 2'd0;
	localparam logic [1:0] ACT_QUERY   = 2'd1;
	localparam logic [1:0] ACT_RESTART = 2'd2;

	typedef enum logic [1:0] {
		FOP_NONE,
		FOP_WORD4,
		FOP_HALF,
		FOP_LAST
	} fin_op_t;

	typedef struct packed {
		logic    add_byte;
		logic    restart;
		logic    fin_start;
		fin_op_t fin_op;
		logic    out_load;
	} bxsh_cmd_t;

	typedef struct packed {
		logic [2:0] pend_cnt;
	} bxsh_stat_t;

	function automatic logic [HASH_W-1:0] mix_a(input logic [HASH_W-1:0] h,
	                                            input logic [HASH_W-1:0] w);
		mix_a = h ^ ~((h << 11) + (w ^ (h >> 5)));
	endfunction

	function automatic logic [HASH_W-1:0] mix_b(input logic [HASH_W-1:0] h,
	                                            input logic [HASH_W-1:0] w);
		logic [HASH_W-1:0] prod;
		prod  = w * (h >> 3);
		mix_b = h ^ (h << 7) ^ prod;
	endfunction

	function automatic logic [HASH_W-1:0] mix_group(input logic [HASH_W-1:0] h,
	                                                input logic [HASH_W-1:0] w1,
	                                                input logic [HASH_W-1:0] w2);
		logic [HASH_W-1:0] prod;
		prod      = w1 * (h >> 3);
		mix_group = h ^ (h << 7) ^ prod ^ ~((h << 11) + (w2 ^ (h >> 5)));
	endfunction

endpackage

@@ rtl/core/bxsh_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bxsh_in_if
// Input channel: action code and stream byte with valid/ready.
// ----------------------------------------------------------------------------
interface bxsh_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] data_byte;

	modport source (output valid, output action, output data_byte, input ready);
	modport sink (input valid, input action, input data_byte, output ready);
endinterface

@@ rtl/core/bxsh_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bxsh_out_if
// Output channel: hash value and byte count with valid/ready.
// ----------------------------------------------------------------------------
interface bxsh_out_if;
	logic                                valid;
	logic                                ready;
	logic [bxsh_pkg::HASH_W-1:0]         hash_value;
	logic [bxsh_pkg::COUNT_OUT_W-1:0]    byte_count;

	modport source (output valid, output hash_value, output byte_count, input ready);
	modport sink (input valid, input hash_value, input byte_count, output ready);
endinterface

@@ rtl/core/bxsh_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bxsh_dp
// Datapath: seed, running hash, pending bytes, byte count, query finaliser
// and the output payload register.
// ----------------------------------------------------------------------------
module bxsh_dp #(
	parameter int COUNT_BITS = bxsh_pkg::COUNT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bxsh_pkg::HASH_W-1:0]       cfg_wdata,
	input  logic [7:0]                        data_byte,
	input  bxsh_pkg::bxsh_cmd_t               cmd,
	output bxsh_pkg::bxsh_stat_t              stat,
	output logic [bxsh_pkg::HASH_W-1:0]       hash_value,
	output logic [bxsh_pkg::COUNT_OUT_W-1:0]  byte_count
);

	logic [bxsh_pkg::HASH_W-1:0]      seed_q;
	logic [bxsh_pkg::HASH_W-1:0]      hash_q;
	logic [55:0]                      pend_q;
	logic [2:0]                       pcnt_q;
	logic [COUNT_BITS-1:0]            cnt_q;
	logic [bxsh_pkg::HASH_W-1:0]      fin_h_q;
	logic [1:0]                       loop_q;
	logic [bxsh_pkg::HASH_W-1:0]      out_hash_q;
	logic [bxsh_pkg::COUNT_OUT_W-1:0] out_cnt_q;

	logic [63:0]                      group_word;
	logic [bxsh_pkg::HASH_W-1:0]      word4;
	logic [bxsh_pkg::HASH_W-1:0]      half;
	logic [bxsh_pkg::HASH_W-1:0]      fin_next;
	logic [bxsh_pkg::HASH_W-1:0]      last_prod;

	assign group_word = {pend_q, data_byte};
	assign stat.pend_cnt = pcnt_q;

	// oldest four pending bytes, big-endian
	always_comb begin
		case (pcnt_q[1:0])
			2'd0:    word4 = pend_q[31:0];
			2'd1:    word4 = pend_q[39:8];
			2'd2:    word4 = pend_q[47:16];
			default: word4 = pend_q[55:24];
		endcase
	end

	assign half      = pcnt_q[0] ? {16'd0, pend_q[23:8]} : {16'd0, pend_q[15:0]};
	assign last_prod = fin_h_q * bxsh_pkg::FINAL_MUL;

	always_comb begin
		case (cmd.fin_op)
			bxsh_pkg::FOP_WORD4: fin_next = bxsh_pkg::mix_a(fin_h_q, word4);
			bxsh_pkg::FOP_HALF:  fin_next = (loop_q != 2'd0) ? bxsh_pkg::mix_b(fin_h_q, half)
			                                                  : bxsh_pkg::mix_a(fin_h_q, half);
			bxsh_pkg::FOP_LAST:  fin_next = fin_h_q + (({24'd0, pend_q[7:0]} ^ last_prod)
			                                + {30'd0, loop_q});
			default:             fin_next = fin_h_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			hash_q <= '0;
			pend_q <= '0;
			pcnt_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (cfg_we) begin
				seed_q <= cfg_wdata;
			end
			if (cmd.restart) begin
				hash_q <= seed_q;
				pend_q <= '0;
				pcnt_q <= '0;
				cnt_q  <= '0;
			end else if (cmd.add_byte) begin
				if (cnt_q != {COUNT_BITS{1'b1}}) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (pcnt_q == 3'd7) begin
					hash_q <= bxsh_pkg::mix_group(hash_q, group_word[63:32], group_word[31:0]);
					pend_q <= '0;
					pcnt_q <= '0;
				end else begin
					pend_q <= {pend_q[47:0], data_byte};
					pcnt_q <= pcnt_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_h_q <= '0;
			loop_q  <= '0;
		end else if (cmd.fin_start) begin
			fin_h_q <= hash_q;
			loop_q  <= 2'd0;
		end else if (cmd.fin_op != bxsh_pkg::FOP_NONE) begin
			fin_h_q <= fin_next;
			if (cmd.fin_op == bxsh_pkg::FOP_WORD4) begin
				loop_q <= 2'd1;
			end else if (cmd.fin_op == bxsh_pkg::FOP_HALF) begin
				loop_q <= loop_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_hash_q <= fin_h_q;
			out_cnt_q  <= bxsh_pkg::COUNT_OUT_W'(cnt_q);
		end
	end

	assign hash_value = out_hash_q;
	assign byte_count = out_cnt_q;

endmodule

@@ rtl/core/bxsh_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bxsh_ctrl
// Controller: decodes input beats, sequences query finalisation and owns
// the output valid flag.
// ----------------------------------------------------------------------------
module bxsh_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           action,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  bxsh_pkg::bxsh_stat_t stat,
	output bxsh_pkg::bxsh_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_WORD4,
		S_HALF,
		S_LAST,
		S_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   in_fire;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '{add_byte: 1'b0, restart: 1'b0, fin_start: 1'b0,
		        fin_op: bxsh_pkg::FOP_NONE, out_load: 1'b0};
		case (state_q)
			S_IDLE: begin
				cmd.add_byte  = in_fire && (action == bxsh_pkg::ACT_ADD);
				cmd.restart   = in_fire && (action == bxsh_pkg::ACT_RESTART);
				cmd.fin_start = in_fire && (action == bxsh_pkg::ACT_QUERY);
			end
			S_WORD4: cmd.fin_op = bxsh_pkg::FOP_WORD4;
			S_HALF:  cmd.fin_op = bxsh_pkg::FOP_HALF;
			S_LAST:  cmd.fin_op = bxsh_pkg::FOP_LAST;
			S_DONE:  cmd.out_load = !out_valid_q || out_ready;
			default: cmd.fin_op = bxsh_pkg::FOP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.fin_start) begin
						if (stat.pend_cnt == 3'd0) begin
							state_q <= S_DONE;
						end else if (stat.pend_cnt[2]) begin
							state_q <= S_WORD4;
						end else if (stat.pend_cnt[1]) begin
							state_q <= S_HALF;
						end else begin
							state_q <= S_LAST;
						end
					end
				end
				S_WORD4: begin
					if (stat.pend_cnt[1]) begin
						state_q <= S_HALF;
					end else if (stat.pend_cnt[0]) begin
						state_q <= S_LAST;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_HALF: begin
					state_q <= stat.pend_cnt[0] ? S_LAST : S_DONE;
				end
				S_LAST: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (cmd.out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_query_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && action == bxsh_pkg::ACT_QUERY) |=> !in_ready)
		else $error("input still ready after a query beat");

	a_empty_query_done: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && action == bxsh_pkg::ACT_QUERY && stat.pend_cnt == 3'd0)
		|=> state_q == S_DONE)
		else $error("query with no pending bytes did not go straight to done");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("output register overwritten while full");

	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside the done state");

endmodule

@@ rtl/core/block_xor_shift_hash32.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_xor_shift_hash32
// Incremental 32-bit xor/shift hash over a byte stream, folded in 8-byte
// groups, with a query that finalises the pending bytes.
// ----------------------------------------------------------------------------
// usage
//   in_ch beats carry an action and a byte: add folds the byte into the
//   running state, query asks for the hash and byte count, restart reloads
//   the seed. add and restart give no result, so the input runs at one beat
//   per cycle between queries.
//   a query drops in_ch.ready through the finalisation steps that the number
//   of pending bytes calls for (four-byte word, two-byte word, last byte) and
//   through the result hand-off to the output register; each step uses at most
//   one multiply.
//   the result beat appears on out_ch from a registered output; while it
//   waits to be taken, add and restart beats are still accepted. a further
//   query completes its steps and then holds until the output is free.
//   cfg_we/cfg_wdata write the seed, used from the next restart on.
//   after reset the seed, hash, pending bytes and count are all zero.
// ----------------------------------------------------------------------------
module block_xor_shift_hash32 #(
	parameter int COUNT_BITS = bxsh_pkg::COUNT_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bxsh_pkg::HASH_W-1:0] cfg_wdata,
	bxsh_in_if.sink                     in_ch,
	bxsh_out_if.source                  out_ch
);

	bxsh_pkg::bxsh_cmd_t  cmd;
	bxsh_pkg::bxsh_stat_t stat;

	bxsh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.action    (in_ch.action),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bxsh_dp #(
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.data_byte  (in_ch.data_byte),
		.cmd        (cmd),
		.stat       (stat),
		.hash_value (out_ch.hash_value),
		.byte_count (out_ch.byte_count)
	);

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the incremental xor/shift hash block. A directed
// table covers every action, the byte extremes, each pending count at query
// time, the group fold, seed writes and restart. Three random phases follow,
// each with its own seed and input/output idling mix, none in the last. Every
// query result is checked against the table or a shadow copy of the hash state.
// ----------------------------------------------------------------------------
module tb_top;
	import bxsh_pkg::*;

	localparam int HALF_PERIOD    = 4;
	localparam int RESET_CYCLES   = 10;
	localparam int SETTLE_CYCLES  = 8;
	localparam int STALL_LIMIT    = 2000;
	localparam int RAND_PER_PHASE = 265;
	localparam int DIR_ROWS       = 24;

	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]             action;
		logic [7:0]             data;
		logic                   typed;
		logic [HASH_W-1:0]      hash;
		logic [COUNT_OUT_W-1:0] count;
	} beat_row_t;

	typedef struct packed {
		logic [HASH_W-1:0]      hash;
		logic [COUNT_OUT_W-1:0] count;
	} hash_res_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [HASH_W-1:0]   cfg_wdata;

	bxsh_in_if  in_ch ();
	bxsh_out_if out_ch ();

	block_xor_shift_hash32 i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// shadow state of the hash
	logic [HASH_W-1:0]      seed_shadow;
	logic [HASH_W-1:0]      hash_shadow;
	logic [55:0]            pend_bytes;
	int unsigned            pend_n;
	logic [COUNT_OUT_W-1:0] byte_total;

	hash_res_t hash_due_q[$];

	int snd_idle_pct;
	int rcv_idle_pct;
	int mismatches;
	int beats_sent;
	int results_checked;
	int stall_cycles;

	beat_row_t dir_tab [DIR_ROWS] = '{
		'{ACT_QUERY,   8'h00, 1'b1, 32'h0000_0000, 48'h0},
		'{ACT_UNUSED,  8'hff, 1'b0, 32'h0,         48'h0},
		'{ACT_QUERY,   8'h00, 1'b1, 32'h0000_0000, 48'h0},
		'{ACT_ADD,     8'h00, 1'b0, 32'h0,         48'h0},
		'{ACT_QUERY,   8'h00, 1'b0, 32'h0,         48'h0},
		'{ACT_ADD,     8'hff, 1'b0, 32'h0,         48'h0},
		'{ACT_QUERY,   8'h00, 1'b0, 32'h0,         48'h0},
		'{ACT_ADD,     8'h80, 1'b0, 32'h0,         48'h0},
		'{ACT_QUERY,   8'hff, 1'b0, 32'h0,         48'h0},
		'{ACT_ADD,     8'h01, 1'b0, 32'h0,         48'h0},
		'{ACT_QUERY,   8'h00, 1'b0, 32'h0,         48'h0},
		'{ACT_ADD,     8'h7f, 1'b0, 32'h0,         48'h0},
		'{ACT_QUERY,   8'h00, 1'b0, 32'h0,         48'h0},
		'{ACT_ADD,     8'hfe, 1'b0, 32'h0,         48'h0},
		'{ACT_QUERY,   8'h00, 1'b0, 32'h0,         48'h0},
		'{ACT_ADD,     8'h55, 1'b0, 32'h0,         48'h0},
		'{ACT_QUERY,   8'h00, 1'b0, 32'h0,         48'h0},
		'{ACT_ADD,     8'haa, 1'b0, 32'h0,         48'h0},
		'{ACT_QUERY,   8'h00, 1'b0, 32'h0,         48'h0},
		'{ACT_RESTART, 8'h5a, 1'b0, 32'h0,         48'h0},
		'{ACT_QUERY,   8'h00, 1'b1, 32'hffff_ffff, 48'h0},
		'{ACT_ADD,     8'hff, 1'b0, 32'h0,         48'h0},
		'{ACT_ADD,     8'h00, 1'b0, 32'h0,         48'h0},
		'{ACT_QUERY,   8'h00, 1'b0, 32'h0,         48'h0}
	};

	initial begin
		clk = 1'b0;
	end

	always begin
		#HALF_PERIOD clk = ~clk;
	end

	function automatic logic [HASH_W-1:0] xor_add_step(input logic [HASH_W-1:0] h,
	                                                   input logic [HASH_W-1:0] w);
		logic [HASH_W-1:0] sum;
		sum = (h << 11) + (w ^ (h >> 5));
		return h ^ ~sum;
	endfunction

	function automatic logic [HASH_W-1:0] xor_mul_step(input logic [HASH_W-1:0] h,
	                                                   input logic [HASH_W-1:0] w);
		logic [HASH_W-1:0] prod;
		prod = w * (h >> 3);
		return h ^ (h << 7) ^ prod;
	endfunction

	function automatic logic [HASH_W-1:0] group_step(input logic [HASH_W-1:0] h,
	                                                 input logic [63:0] grp);
		logic [HASH_W-1:0] prod;
		logic [HASH_W-1:0] sum;
		prod = grp[63:32] * (h >> 3);
		sum  = (h << 11) + (grp[31:0] ^ (h >> 5));
		return h ^ (h << 7) ^ prod ^ ~sum;
	endfunction

	// hash as if the stream ended now, pending bytes folded in
	function automatic logic [HASH_W-1:0] finalised_hash();
		logic [HASH_W-1:0] h;
		logic [HASH_W-1:0] steps;
		logic [HASH_W-1:0] lo;
		logic [HASH_W-1:0] prod;
		logic [55:0]       rest;
		int unsigned       n;
		int unsigned       sh;
		h     = hash_shadow;
		n     = pend_n;
		rest  = pend_bytes;
		steps = '0;
		if (n == 0) begin
			return h;
		end
		if (n >= 4) begin
			sh    = (n - 4) * 8;
			h     = xor_add_step(h, HASH_W'(rest >> sh));
			steps = 1;
			rest  = rest & ((56'd1 << sh) - 56'd1);
			n     = n - 4;
		end
		lo = rest[31:0];
		if (n >= 3) begin
			h     = (steps != 0) ? xor_mul_step(h, lo >> 8) : xor_add_step(h, lo >> 8);
			steps = steps + 1;
			n     = 1;
			lo    = lo & 32'hff;
		end else if (n == 2) begin
			h = (steps != 0) ? xor_mul_step(h, lo) : xor_add_step(h, lo);
			n = 0;
		end
		if (n > 0) begin
			prod = h * FINAL_MUL;
			h    = h + (lo ^ prod) + steps;
		end
		return h;
	endfunction

	task automatic report_mismatch(input string what, input logic [COUNT_OUT_W-1:0] got,
	                               input logic [COUNT_OUT_W-1:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
		mismatches++;
	endtask

	task automatic apply_beat(input beat_row_t row);
		hash_res_t res;
		case (row.action)
			ACT_ADD: begin
				if (byte_total != '1) begin
					byte_total = byte_total + 1'b1;
				end
				if (pend_n >= 7) begin
					hash_shadow = group_step(hash_shadow, {pend_bytes, row.data});
					pend_bytes  = '0;
					pend_n      = 0;
				end else begin
					pend_bytes = {pend_bytes[47:0], row.data};
					pend_n++;
				end
			end
			ACT_QUERY: begin
				if (row.typed) begin
					res.hash  = row.hash;
					res.count = row.count;
				end else begin
					res.hash  = finalised_hash();
					res.count = byte_total;
				end
				hash_due_q.push_back(res);
			end
			ACT_RESTART: begin
				hash_shadow = seed_shadow;
				pend_bytes  = '0;
				pend_n      = 0;
				byte_total  = '0;
			end
			default: begin
			end
		endcase
	endtask

	// called at a falling edge, returns at a falling edge
	task automatic send_beat(input beat_row_t row);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.action    <= row.action;
		in_ch.data_byte <= row.data;
		@(posedge clk);
		while (!in_ch.ready) begin
			@(posedge clk);
		end
		apply_beat(row);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_ch.valid <= 1'b0;
		while (hash_due_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_seed(input logic [HASH_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we      <= 1'b0;
		seed_shadow = value;
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
	end

	always @(posedge clk) begin
		hash_res_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (hash_due_q.size() == 0) begin
				report_mismatch("result with none due", COUNT_OUT_W'(out_ch.hash_value),
				                '0);
			end else begin
				want = hash_due_q.pop_front();
				results_checked++;
				if (out_ch.hash_value !== want.hash) begin
					report_mismatch("hash_value", COUNT_OUT_W'(out_ch.hash_value),
					                COUNT_OUT_W'(want.hash));
				end
				if (out_ch.byte_count !== want.count) begin
					report_mismatch("byte_count", out_ch.byte_count, want.count);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		logic [HASH_W-1:0] phase_seed [3];
		beat_row_t         row;
		int                ph;
		int                counted;
		int                pick;
		bit                paused;

		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_wdata       = '0;
		in_ch.valid     = 1'b0;
		in_ch.action    = ACT_ADD;
		in_ch.data_byte = '0;
		out_ch.ready    = 1'b0;
		snd_idle_pct    = 35;
		rcv_idle_pct    = 49;
		mismatches      = 0;
		beats_sent      = 0;
		results_checked = 0;
		stall_cycles    = 0;
		seed_shadow     = '0;
		hash_shadow     = '0;
		pend_bytes      = '0;
		pend_n          = 0;
		byte_total      = '0;
		phase_seed[0]   = 32'h0000_0000;
		phase_seed[1]   = $urandom;
		phase_seed[2]   = 32'h8000_0001;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// seed write must not touch the running hash until a restart
		write_seed(32'hffff_ffff);
		for (int i = 0; i < DIR_ROWS; i++) begin
			send_beat(dir_tab[i]);
		end

		for (ph = 0; ph < 3; ph++) begin
			snd_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 49 : 0;
			rcv_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 35 : 0;
			drain_results();
			write_seed(phase_seed[ph]);
			row = '{ACT_RESTART, 8'h00, 1'b0, 32'h0, 48'h0};
			send_beat(row);
			counted = 0;
			paused  = 1'b0;
			while (counted < RAND_PER_PHASE) begin
				if (!paused && counted >= RAND_PER_PHASE / 2) begin
					drain_results();
					paused = 1'b1;
				end
				pick = $urandom_range(99);
				row.action = (pick < 70) ? ACT_ADD : (pick < 92) ? ACT_QUERY :
				             (pick < 96) ? ACT_RESTART : ACT_UNUSED;
				if ($urandom_range(9) == 0) begin
					row.data = $urandom_range(1) ? 8'hff : 8'h00;
				end else begin
					row.data = 8'($urandom);
				end
				send_beat(row);
				if (row.action != ACT_UNUSED) begin
					counted++;
				end
			end
		end

		drain_results();
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		$display("run covered %0d input beats and checked %0d query results", beats_sent,
		         results_checked);
		$display("seeds: all-ones, zero, top bit set and one random, three idling mixes");
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/bxsh_pkg.sv
rtl/core/bxsh_in_if.sv
rtl/core/bxsh_out_if.sv
rtl/core/bxsh_dp.sv
rtl/core/bxsh_ctrl.sv
rtl/core/block_xor_shift_hash32.sv
tb/sv/tb_top.sv
